### rtl/pesc_pkg.sv
// Shared constants for the polygon edge scan converter.
// No dependencies; imported by pesc_div and polygon_edge_scan_converter.
package pesc_pkg;

  // Coordinate width default (range 8..32).
  localparam int unsigned COORD_BITS_DEF = 16;

  // Row limit register.
  localparam int unsigned ROW_LIMIT_W   = 15;
  localparam logic [ROW_LIMIT_W-1:0] ROW_LIMIT_RST = 15'd480;

  // APB port geometry: one 32-bit register at byte address 0.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_ROW_LIMIT = 1'b0;

  // Input item kinds.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

endpackage

### rtl/polygon_edge_scan_converter.sv
// Polygon edge scan converter: incremental DDA walk of one edge per row.
// Depends on pesc_pkg and pesc_div.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------
//  input    | in_valid_i / in_ready_o    | mode_i, x_start_i, y_start_i,
//           |                            | x_end_i, y_end_i
//  output   | out_valid_o / out_ready_i  | valid_res_o, row_o, x_pos_o, last_o
//  config   | APB psel/penable/pwrite    | paddr, pwdata, prdata (row_limit)
//
// A step transaction is accepted, then emitted into the output register once
// that is free. A start transaction first waits in ST_DIV, where the radix-2
// divider that forms |dx|/|dy| produces one quotient bit per cycle.
// in_ready_o is high only while the sequencer is idle; the output register
// lets the next transaction be accepted while the previous result waits.
// Reset (rst_ni low, asynchronous) clears the sequencer, the active flag and
// the output valid, and loads row_limit with 480.
module polygon_edge_scan_converter import pesc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  mode_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  valid_res_o,
  output logic [COORD_BITS-1:0] row_o,
  output logic [COORD_BITS-1:0] x_pos_o,
  output logic                  last_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned EW = COORD_BITS + 2;   // error term headroom

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [ROW_LIMIT_W-1:0] row_limit_q;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_ROW_LIMIT);
  assign prdata  = (reg_idx == REG_ROW_LIMIT) ?
                   {{(APB_DATA_W-ROW_LIMIT_W){1'b0}}, row_limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_limit_q <= ROW_LIMIT_RST;
    end else if (cfg_wr) begin
      row_limit_q <= pwdata[ROW_LIMIT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Edge state
  // ---------------------------------------------------------------------------
  logic         active_q;
  logic [W-1:0] cur_row_q, end_row_q, cur_x_q, err_q;
  logic [W-1:0] whole_q, big_q, frac_q, dy_q;
  logic         neg_q;

  logic in_fire, start_fire, emit_fire;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign start_fire = in_fire && (mode_i == MODE_START);

  // Edge set-up: differences, swap so rows increase, magnitudes, end clamp.
  logic [W-1:0]    dx_raw, dy_raw, dx_sw, dy_mag, dx_abs;
  logic [W-1:0]    xs_sw, ys_sw, ye_sw, end_row_d;
  logic            swap, dx_neg, ye_lt_lim;
  logic [W+15:0]   lim_ext;

  assign dx_raw  = x_end_i - x_start_i;
  assign dy_raw  = y_end_i - y_start_i;
  assign swap    = dy_raw[W-1];
  assign dx_sw   = swap ? (W'(0) - dx_raw) : dx_raw;
  assign dy_mag  = swap ? (W'(0) - dy_raw) : dy_raw;   // up to 2^(W-1), unsigned
  assign xs_sw   = swap ? x_end_i   : x_start_i;
  assign ys_sw   = swap ? y_end_i   : y_start_i;
  assign ye_sw   = swap ? y_start_i : y_end_i;
  assign dx_neg  = dx_sw[W-1];
  assign dx_abs  = dx_neg ? (W'(0) - dx_sw) : dx_sw;

  assign lim_ext   = {{(W+1){1'b0}}, row_limit_q};
  assign ye_lt_lim = $signed({{16{ye_sw[W-1]}}, ye_sw}) < $signed(lim_ext);
  assign end_row_d = ye_lt_lim ? ye_sw : lim_ext[W-1:0];

  // Divider: |dx| / |dy|
  logic         div_done;
  logic [W-1:0] div_quot, div_rem;
  logic [W-1:0] k_val, big_val, sgn_val;

  pesc_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_fire),
    .dividend_i (dx_abs),
    .divisor_i  (dy_mag),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // horizontal edge: quotient is ignored, k and remainder are zero
  assign sgn_val = neg_q ? '1 : W'(1);
  assign k_val   = (dy_q == '0) ? '0 : (neg_q ? (W'(0) - div_quot) : div_quot);
  assign big_val = k_val + sgn_val;

  // Emit step: one DDA advance
  logic          fin;
  logic [EW-1:0] e_sum, e_new;
  logic          e_pos;

  assign fin   = !($signed(cur_row_q) < $signed(end_row_q));
  assign e_sum = {{2{err_q[W-1]}}, err_q} + {2'b00, frac_q};
  assign e_pos = !e_sum[EW-1] && (e_sum != '0);
  assign e_new = e_pos ? (e_sum - {2'b00, dy_q}) : e_sum;

  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_o || out_ready_i);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (mode_i == MODE_START) ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      active_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start_fire) begin
        active_q <= 1'b1;
      end else if (emit_fire && active_q && fin) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_fire) begin
      cur_row_q <= ys_sw;
      cur_x_q   <= xs_sw;
      end_row_q <= end_row_d;
      dy_q      <= dy_mag;
      neg_q     <= dx_neg;
      err_q     <= '0;
    end else if (emit_fire && active_q && !fin) begin
      cur_x_q   <= cur_x_q + (e_pos ? big_q : whole_q);
      err_q     <= e_new[W-1:0];
      cur_row_q <= cur_row_q + W'(1);
    end
    if ((state_q == ST_DIV) && div_done) begin
      whole_q <= k_val;
      big_q   <= big_val;
      frac_q  <= (dy_q == '0) ? '0 : div_rem;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic         out_valid_q;
  logic         res_q, last_q;
  logic [W-1:0] row_q, xpos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // idle step (no active edge) returns an all-zero result
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      res_q  <= active_q;
      row_q  <= active_q ? cur_row_q : '0;
      xpos_q <= active_q ? cur_x_q   : '0;
      last_q <= active_q && fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_q;
  assign row_o       = row_q;
  assign x_pos_o     = xpos_q;
  assign last_o      = last_q;

endmodule

### rtl/pesc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pesc_pkg.
module pesc_div import pesc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] dividend_i,
  input  logic [COORD_BITS-1:0] divisor_i,
  output logic                  done_o,
  output logic [COORD_BITS-1:0] quot_o,
  output logic [COORD_BITS-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(COORD_BITS);

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [COORD_BITS-1:0] rem_q, quo_q, dvs_q;
  logic [COORD_BITS:0]   rem_sh, rem_sub;
  logic                  ge, last;

  // one shift / compare / subtract step
  assign rem_sh  = {rem_q, quo_q[COORD_BITS-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  assign last    = (cnt_q == CNT_W'(COORD_BITS - 1));

  assign done_o = busy_q && last;
  assign quot_o = {quo_q[COORD_BITS-2:0], ge};
  assign rem_o  = rem_sub[COORD_BITS-1:0];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_sub[COORD_BITS-1:0];
      quo_q <= quot_o;
    end
  end

endmodule
